// ===== src/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the compensator checkers.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/fopwm_pkg.sv =====
//------------------------------------------------------------------------------
// fopwm_pkg
// Types and constants of the first-order compensator with PWM duty output.
//------------------------------------------------------------------------------
package fopwm_pkg;

  localparam int SAMPLE_BITS_DEF   = 8;
  localparam int FRACTION_BITS_DEF = 10;

  localparam int GAIN_W   = 16;
  localparam int LEVEL_W  = 8;
  localparam int STATE_W  = 32;
  localparam int PROD_W   = GAIN_W + STATE_W;
  localparam int DUTY_W   = 8;
  localparam int WHOLE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NEW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;

  // reset values
  localparam logic [LEVEL_W-1:0]       REFERENCE_RST = 8'd51;
  localparam logic signed [GAIN_W-1:0] GAIN_NEW_RST  = 16'sd4403;
  localparam logic signed [GAIN_W-1:0] GAIN_OLD_RST  = -16'sd4328;
  localparam logic signed [GAIN_W-1:0] GAIN_FB_RST   = 16'sd1024;
  localparam logic [LEVEL_W-1:0]       PERIOD_RST    = 8'd99;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_SAT,
    ST_DUTY,
    ST_DIV,
    ST_DONE
  } fopwm_state_e;

endpackage

// ===== src/first_order_compensator_pwm_core.sv =====
//------------------------------------------------------------------------------
// first_order_compensator_pwm_core
// First-order IIR compensator on converter samples with a PWM duty result.
//------------------------------------------------------------------------------
// The core takes one sample at a time: after a transaction on the input side
// the block computes (three coefficient products and one duty product on a
// single shared 16x32 signed multiplier, plus accumulate, saturate and
// divide-by-255 steps) and holds in_stall_o high until it returns to idle.
// The result sits in an output register, so the next sample can be taken while
// it waits to be collected; if it is still waiting when the following result
// is ready, the core holds in its last step with in_stall_o high until the
// output side takes it. Output is y = c0*e0 + c1*e1 + c2*y_prev with the
// errors held before the current sample, so duty lags the sample by one step.
// Configuration writes are always ready and must only be issued while idle.
module first_order_compensator_pwm_core #(
  parameter int SAMPLE_BITS   = fopwm_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = fopwm_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fopwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fopwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [SAMPLE_BITS-1:0]             adc_sample_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fopwm_pkg::DUTY_W-1:0]       duty_count_o,
  output logic signed [fopwm_pkg::WHOLE_W-1:0] control_whole_o,
  output logic                               clamped_o
);
  import fopwm_pkg::*;

  localparam int ERR_W   = SAMPLE_BITS + 1;
  localparam int SUM_W   = GAIN_W + ERR_W + 1;
  localparam int ACC_W   = ((SUM_W + FRACTION_BITS) > PROD_W ?
                            SUM_W + FRACTION_BITS : PROD_W) + 1;
  localparam logic [STATE_W-1:0] FullScale =
    STATE_W'({FULL_LEVEL}) << FRACTION_BITS;

  // configuration registers
  logic [LEVEL_W-1:0]       ref_q, ref_d;
  logic signed [GAIN_W-1:0] gn_q, gn_d, go_q, go_d, gf_q, gf_d;
  logic [LEVEL_W-1:0]       period_q, period_d;

  // compensator state
  logic signed [ERR_W-1:0]   e0_q, e0_d, e1_q, e1_d;
  logic signed [STATE_W-1:0] last_q, last_d;

  // datapath
  fopwm_state_e              state_q, state_d;
  logic [SAMPLE_BITS-1:0]    sample_q, sample_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [DUTY_W-1:0]         duty_q, duty_d;

  logic                      out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]         out_duty_q, out_duty_d;
  logic signed [WHOLE_W-1:0] out_whole_q, out_whole_d;
  logic                      out_clip_q, out_clip_d;

  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [STATE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   prod_ext, acc_sh;
  logic [ACC_W-32:0]         acc_hi;
  logic [STATE_W-1:0]        yc;
  logic signed [STATE_W-1:0] whole_sh;
  logic [STATE_W-WHOLE_W:0]  whole_hi;
  logic [15:0]               div_q, est255, div_r;
  logic [24:0]               div_t;
  logic [DUTY_W-1:0]         est;

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign duty_count_o    = out_duty_q;
  assign control_whole_o = out_whole_q;
  assign clamped_o       = out_clip_q;

  // configuration decode
  always_comb begin
    ref_d    = ref_q;
    gn_d     = gn_q;
    go_d     = go_q;
    gf_d     = gf_q;
    period_d = period_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REFERENCE: ref_d    = cfg_data_i[LEVEL_W-1:0];
        CFG_GAIN_NEW:  gn_d     = signed'(cfg_data_i);
        CFG_GAIN_OLD:  go_d     = signed'(cfg_data_i);
        CFG_GAIN_FB:   gf_d     = signed'(cfg_data_i);
        CFG_PERIOD:    period_d = cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp of the stored output to 0..255.0
  always_comb begin
    if (last_q[STATE_W-1])               yc = '0;
    else if (unsigned'(last_q) > FullScale) yc = FullScale;
    else                                 yc = unsigned'(last_q);
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      ST_MUL0: begin
        mul_a = gn_q;
        mul_b = {{(STATE_W-ERR_W){e0_q[ERR_W-1]}}, e0_q};
      end
      ST_MUL1: begin
        mul_a = go_q;
        mul_b = {{(STATE_W-ERR_W){e1_q[ERR_W-1]}}, e1_q};
      end
      ST_MUL2: begin
        mul_a = gf_q;
        mul_b = last_q;
      end
      ST_DUTY: begin
        mul_a = signed'({{(GAIN_W-LEVEL_W){1'b0}}, period_q});
        mul_b = signed'(yc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_sh   = acc_q >>> FRACTION_BITS;   // floor toward minus infinity
  assign acc_hi   = acc_sh[ACC_W-1:31];
  assign whole_sh = last_q >>> FRACTION_BITS;
  assign whole_hi = whole_sh[STATE_W-1:WHOLE_W-1];

  // floor(q / 255): estimate with q*257/2^16 (never high), then one correction
  assign div_q  = prod_q[FRACTION_BITS+15 -: 16];
  assign div_t  = {1'b0, div_q, 8'd0} + {9'd0, div_q};
  assign est    = div_t[23:16];
  assign est255 = {est, 8'd0} - {8'd0, est};
  assign div_r  = div_q - est255;

  // sequencer
  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    duty_d      = duty_q;
    e0_d        = e0_q;
    e1_d        = e1_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_duty_d  = out_duty_q;
    out_whole_d = out_whole_q;
    out_clip_d  = out_clip_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sample_d = adc_sample_i;
          state_d  = ST_MUL0;
        end
      end
      ST_MUL0: begin
        prod_d  = mul_p;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        prod_d  = mul_p;
        acc_d   = prod_ext;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = mul_p;
        acc_d   = (acc_q + prod_ext) <<< FRACTION_BITS;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + prod_ext;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if ((&acc_hi) || !(|acc_hi)) last_d = acc_sh[STATE_W-1:0];
        else if (acc_sh[ACC_W-1])    last_d = {1'b1, {(STATE_W-1){1'b0}}};
        else                         last_d = {1'b0, {(STATE_W-1){1'b1}}};
        e1_d    = e0_q;
        e0_d    = signed'({{(ERR_W-LEVEL_W){1'b0}}, ref_q}) -
                  signed'({1'b0, sample_q});
        state_d = ST_DUTY;
      end
      ST_DUTY: begin
        prod_d  = mul_p;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        duty_d  = (div_r >= 16'(FULL_LEVEL)) ? est + 8'd1 : est;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_duty_d  = duty_q;
          out_clip_d  = last_q[STATE_W-1] || (unsigned'(last_q) > FullScale);
          if ((&whole_hi) || !(|whole_hi))
            out_whole_d = whole_sh[WHOLE_W-1:0];
          else if (whole_sh[STATE_W-1])
            out_whole_d = {1'b1, {(WHOLE_W-1){1'b0}}};
          else
            out_whole_d = {1'b0, {(WHOLE_W-1){1'b1}}};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ref_q       <= REFERENCE_RST;
      gn_q        <= GAIN_NEW_RST;
      go_q        <= GAIN_OLD_RST;
      gf_q        <= GAIN_FB_RST;
      period_q    <= PERIOD_RST;
      e0_q        <= '0;
      e1_q        <= '0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ref_q       <= ref_d;
      gn_q        <= gn_d;
      go_q        <= go_d;
      gf_q        <= gf_d;
      period_q    <= period_d;
      e0_q        <= e0_d;
      e1_q        <= e1_d;
      last_q      <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    duty_q      <= duty_d;
    out_duty_q  <= out_duty_d;
    out_whole_q <= out_whole_d;
    out_clip_q  <= out_clip_d;
  end

endmodule

// ===== src/fopwm_checker.sv =====
//------------------------------------------------------------------------------
// fopwm_checker
// Port-level checks for the compensator core, attached by bind.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module fopwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  duty_count_o,
  input logic [15:0] control_whole_o,
  input logic        clamped_o
);

  // a held result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a held result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(duty_count_o) && $stable(control_whole_o) && $stable(clamped_o))

  // once a sample is taken the core is busy computing
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // an unclamped output lies in 0..255, so its integer part does too
  `ASSERT_IMPLIES(a_unclamped_range, clk_i, rst_ni, out_valid_o && !clamped_o, control_whole_o[15:8] == 8'd0)

endmodule

bind first_order_compensator_pwm_core fopwm_checker u_fopwm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .duty_count_o    (duty_count_o),
  .control_whole_o (control_whole_o),
  .clamped_o       (clamped_o)
);
